FILE: rtl/core/ils_pkg.sv
// Shared types and constants for the indexed list store.
// Depends on nothing; used by ils_shift_engine and indexed_list_store_core.
`default_nettype none

package ils_pkg;

    localparam int CAPACITY = 64;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int LEN_W   = 7;
    localparam int VALUE_W = 32;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

    typedef enum logic [1:0] {
        ENG_NONE   = 2'd0,
        ENG_READ   = 2'd1,
        ENG_INSERT = 2'd2,
        ENG_DELETE = 2'd3
    } eng_op_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic                      hit;
        logic                      rejected;
        logic [LEN_W-1:0]          length;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic               ack;
        eng_op_t            op;
        logic [IDX_W-1:0]   pos;
        logic [CNT_W-1:0]   count;
        logic [VALUE_W-1:0] value;
    } eng_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] rdata;
    } eng_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ils_shift_engine.sv
// Entry memory and the sequencer that reads, inserts and deletes entries,
// moving one entry per cycle through a single read and a single write port.
// Depends on ils_pkg.
`default_nettype none

module ils_shift_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ils_pkg::eng_req_t  req,
    output ils_pkg::eng_stat_t      stat
);

    typedef enum logic [4:0] {
        E_IDLE  = 5'b00001,
        E_READ  = 5'b00010,
        E_SHIFT = 5'b00100,
        E_FINAL = 5'b01000,
        E_DONE  = 5'b10000
    } eng_state_t;

    eng_state_t state_reg, state_next;
    ils_pkg::eng_op_t op_reg, op_next;
    logic [ils_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [ils_pkg::IDX_W-1:0]   rd_addr_reg, rd_addr_next;
    logic                        pend_reg, pend_next;
    logic [ils_pkg::IDX_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [ils_pkg::IDX_W-1:0]   pos_reg, pos_next;
    logic [ils_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [ils_pkg::VALUE_W-1:0] rdata_reg;

    logic [ils_pkg::VALUE_W-1:0] mem [ils_pkg::CAPACITY];

    logic                        mem_re;
    logic [ils_pkg::IDX_W-1:0]   mem_ra;
    logic                        mem_we;
    logic [ils_pkg::IDX_W-1:0]   mem_wa;
    logic [ils_pkg::VALUE_W-1:0] mem_wd;
    logic [ils_pkg::CNT_W-1:0]   cnt_m1;
    logic [ils_pkg::CNT_W-1:0]   pos_ext;

    assign cnt_m1  = req.count - ils_pkg::CNT_W'(1);
    assign pos_ext = ils_pkg::CNT_W'(req.pos);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_ra];
        end
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        rem_next       = rem_reg;
        rd_addr_next   = rd_addr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        mem_re         = 1'b0;
        mem_ra         = rd_addr_reg;
        mem_we         = 1'b0;
        mem_wa         = pend_addr_reg;
        mem_wd         = rdata_reg;

        unique case (state_reg)
            E_IDLE: begin
                pend_next = 1'b0;
                if (req.start) begin
                    op_next    = req.op;
                    pos_next   = req.pos;
                    value_next = req.value;
                    unique case (req.op)
                        ils_pkg::ENG_READ: begin
                            state_next = E_READ;
                        end
                        ils_pkg::ENG_INSERT: begin
                            rem_next     = req.count - pos_ext;
                            rd_addr_next = cnt_m1[ils_pkg::IDX_W-1:0];
                            state_next   = E_SHIFT;
                        end
                        ils_pkg::ENG_DELETE: begin
                            rem_next     = cnt_m1 - pos_ext;
                            rd_addr_next = req.pos + ils_pkg::IDX_W'(1);
                            state_next   = E_SHIFT;
                        end
                        default: begin
                            state_next = E_DONE;
                        end
                    endcase
                end
            end
            E_READ: begin
                mem_re     = 1'b1;
                mem_ra     = pos_reg;
                state_next = E_DONE;
            end
            E_SHIFT: begin
                // Read one entry per cycle; the entry read last cycle is written
                // one place up (insert) or down (delete) in this cycle.
                if (rem_reg != '0) begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    rem_next  = rem_reg - ils_pkg::CNT_W'(1);
                    if (op_reg == ils_pkg::ENG_INSERT) begin
                        pend_addr_next = rd_addr_reg + ils_pkg::IDX_W'(1);
                        rd_addr_next   = rd_addr_reg - ils_pkg::IDX_W'(1);
                    end else begin
                        pend_addr_next = rd_addr_reg - ils_pkg::IDX_W'(1);
                        rd_addr_next   = rd_addr_reg + ils_pkg::IDX_W'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    mem_we = 1'b1;
                end
                if (rem_reg == '0 && !pend_reg) begin
                    state_next = E_FINAL;
                end
            end
            E_FINAL: begin
                if (op_reg == ils_pkg::ENG_INSERT) begin
                    mem_we = 1'b1;
                    mem_wa = pos_reg;
                    mem_wd = value_reg;
                end
                state_next = E_DONE;
            end
            E_DONE: begin
                if (req.ack) begin
                    state_next = E_IDLE;
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
        op_reg        <= op_next;
        rem_reg       <= rem_next;
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
        pos_reg       <= pos_next;
        value_reg     <= value_next;
    end

    assign stat.done  = (state_reg == E_DONE);
    assign stat.rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/indexed_list_store_core.sv
// Indexed list store: an ordered list of signed 32-bit values with get, add and delete.
// An add or delete moves entries in the shift engine: those at and above the position for an
// add, those above it for a delete. A get that hits reads its entry from the engine memory.
// One item at a time: the next item is taken once the result is registered, and the result
// is registered only when the output register is empty or being read.
// Reset empties the list at once; the entry memory itself is not cleared.
// Depends on ils_pkg and ils_shift_engine.
`default_nettype none

module indexed_list_store_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ils_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ils_pkg::out_item_t      m_data
);

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_BUSY = 2'b10
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [ils_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        start_reg;
    ils_pkg::eng_op_t            op_reg, op_c;
    logic [ils_pkg::IDX_W-1:0]   epos_reg, epos_c;
    logic [ils_pkg::CNT_W-1:0]   ecount_reg;
    logic [ils_pkg::VALUE_W-1:0] evalue_reg;
    logic                        hit_reg, hit_c;
    logic                        rej_reg, rej_c;
    logic                        miss_reg, miss_c;
    logic [ils_pkg::LEN_W-1:0]   len_reg;
    logic                        m_valid_reg;
    ils_pkg::out_item_t          out_reg;

    ils_pkg::eng_req_t  req;
    ils_pkg::eng_stat_t stat;

    logic                      accept;
    logic                      load;
    logic [ils_pkg::CMP_W-1:0] pos_c;
    logic [ils_pkg::CMP_W-1:0] cnt_c;
    logic [ils_pkg::CMP_W-1:0] ins_pos;
    logic                      is_add;
    logic                      full;

    assign s_ready = (state_reg == T_IDLE);
    assign accept  = s_valid && s_ready;
    assign load    = (state_reg == T_BUSY) && stat.done && (!m_valid_reg || m_ready);

    assign pos_c = ils_pkg::CMP_W'(s_data.position);
    assign cnt_c = ils_pkg::CMP_W'(count_reg);
    assign full  = (count_reg == ils_pkg::CNT_W'(ils_pkg::CAPACITY));

    // Decode the command against the current length.
    always_comb begin
        op_c       = ils_pkg::ENG_NONE;
        epos_c     = pos_c[ils_pkg::IDX_W-1:0];
        hit_c      = 1'b0;
        rej_c      = 1'b0;
        miss_c     = 1'b0;
        count_next = count_reg;
        is_add     = 1'b0;
        ins_pos    = pos_c;

        case (s_data.command)
            ils_pkg::CMD_GET: begin
                if (pos_c < cnt_c) begin
                    op_c  = ils_pkg::ENG_READ;
                    hit_c = 1'b1;
                end else begin
                    miss_c = 1'b1;
                end
            end
            ils_pkg::CMD_ADD_HEAD: begin
                is_add  = 1'b1;
                ins_pos = '0;
            end
            ils_pkg::CMD_ADD_TAIL: begin
                is_add  = 1'b1;
                ins_pos = cnt_c;
            end
            ils_pkg::CMD_ADD_AT: begin
                is_add = 1'b1;
            end
            ils_pkg::CMD_DELETE: begin
                if (pos_c < cnt_c) begin
                    op_c       = ils_pkg::ENG_DELETE;
                    hit_c      = 1'b1;
                    count_next = count_reg - ils_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (is_add && ins_pos <= cnt_c) begin
            epos_c = ins_pos[ils_pkg::IDX_W-1:0];
            if (full) begin
                rej_c = 1'b1;
            end else begin
                op_c       = ils_pkg::ENG_INSERT;
                hit_c      = 1'b1;
                count_next = count_reg + ils_pkg::CNT_W'(1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    state_next = T_BUSY;
                end
            end
            T_BUSY: begin
                if (load) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            count_reg   <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= accept;
            if (accept) begin
                count_reg <= count_next;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= op_c;
            epos_reg   <= epos_c;
            ecount_reg <= count_reg;
            evalue_reg <= s_data.value;
            hit_reg    <= hit_c;
            rej_reg    <= rej_c;
            miss_reg   <= miss_c;
            len_reg    <= ils_pkg::LEN_W'(count_next);
        end
        if (load) begin
            if (op_reg == ils_pkg::ENG_READ) begin
                out_reg.read_value <= stat.rdata;
            end else if (miss_reg) begin
                out_reg.read_value <= '1;
            end else begin
                out_reg.read_value <= '0;
            end
            out_reg.hit      <= hit_reg;
            out_reg.rejected <= rej_reg;
            out_reg.length   <= len_reg;
        end
    end

    assign req.start = start_reg;
    assign req.ack   = load;
    assign req.op    = op_reg;
    assign req.pos   = epos_reg;
    assign req.count = ecount_reg;
    assign req.value = evalue_reg;

    ils_shift_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .stat    (stat)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
